FILE: rtl/core/okt_pkg.sv
// ----------------------------------------------------------------------------
// okt_pkg
// Shared types and codes for the ordered key table: entry layout, action and
// status codes, and the command and status groups between control and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package okt_pkg;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_UPDATE = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_MINVAL = 3'd4;
  localparam logic [2:0] ACT_MINWGT = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one table entry, key in the lowest bits
  typedef struct packed {
    logic signed [31:0] weight;
    logic [31:0]        value;
    logic [15:0]        key;
  } entry_t;

  typedef struct packed {
    logic       load;      // take a new item
    logic       add;       // append item at the fill position
    logic       scan;      // advance the read pipeline
    logic       minsel;    // track the running minimum
    logic       seek;      // key hit: capture entry, park pointer after it
    logic       upd;       // key hit on update: rewrite value in place
    logic       shift;     // move entries down by one
    logic       dec;       // drop one entry from the count
    logic       finish;    // load the result register
    logic [1:0] res_code;
    logic       res_have;
  } okt_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       empty;
    logic       hit;
    logic       scan_end;
    logic       out_busy;
  } okt_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/ordered_key_table_with_min_search.sv
// ----------------------------------------------------------------------------
// ordered_key_table_with_min_search
// Insertion-ordered key table with first-match lookup, update, remove with
// gap closing, and find-min over value or weight
// ----------------------------------------------------------------------------
// flow: an add or an unknown action goes straight to the result; lookup, update,
//   find-min and remove scan the held entries (one memory read a cycle), and a key hit
//   ends the scan; a remove hit then shifts the later entries down by one place
// throughput: one item at a time, the next is taken the cycle after the result is
//   loaded; a stalled result delays that load
// reset: synchronous, clears the entry count and control; entry memory is not cleared
`default_nettype none

module ordered_key_table_with_min_search import okt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // action
  input  wire logic [79:0] s_tdata,   // key_in, value_in, weight_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [1:0]       m_tuser,   // status
  output logic [87:0]      m_tdata    // key_out, value_out, weight_out, entries_held, pad
);

  okt_cmd_t cmd;
  okt_sts_t sts;

  okt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  okt_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

  // never append into a full table
  a_no_add_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.add |-> !sts.full)
    else $error("append issued with a full table");

  // a full report always comes with the table at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[84:80] == 5'(DEPTH)))
    else $error("full status with wrong entry count");

  // a miss or full result carries no entry
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[79:0] == 80'd0))
    else $error("entry fields not zero on miss or full");

  // only one step of the pointer logic at a time
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.add, cmd.seek, cmd.dec, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: rtl/core/okt_ram.sv
// ----------------------------------------------------------------------------
// okt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module okt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/okt_datapath.sv
// ----------------------------------------------------------------------------
// okt_datapath
// Entry memory, fill count, scan pipeline, key match, running minimum and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module okt_datapath import okt_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [2:0]  s_tuser,
  input  wire logic [79:0] s_tdata,
  input  wire okt_cmd_t    cmd,
  output okt_sts_t         sts,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [1:0]       m_tuser,
  output logic [87:0]      m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(entry_t);

  logic [2:0]    act;
  entry_t        item;
  entry_t        sel;
  logic [CW-1:0] fill;
  logic [CW-1:0] scan_ptr;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;

  logic          out_valid;
  logic [1:0]    out_status;
  entry_t        out_entry;
  logic [4:0]    out_count;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [EW-1:0] rdata_raw;
  entry_t        rdata;
  entry_t        rdata_upd;
  logic          key_hit;
  logic          better;

  okt_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(scan_ptr[AW-1:0]),
    .rdata(rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  always_comb begin
    rdata_upd       = rdata;
    rdata_upd.value = item.value;
  end

  assign key_hit = rd_pend && (rdata.key == item.key);

  // first entry seeds the minimum, later ones replace it only when strictly lower
  always_comb begin
    if (rd_idx == '0) begin
      better = 1'b1;
    end else if (act == ACT_MINVAL) begin
      better = rdata.value < sel.value;
    end else begin
      better = $signed(rdata.weight) < $signed(sel.weight);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill[AW-1:0];
    wdata = item;
    if (cmd.add) begin
      we = 1'b1;
    end else if (cmd.upd) begin
      we    = 1'b1;
      waddr = rd_idx;
      wdata = rdata_upd;
    end else if (cmd.shift && rd_pend) begin
      // entry read from rd_idx moves one place down
      we    = 1'b1;
      waddr = rd_idx - AW'(1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      scan_ptr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_ptr <= '0;
        rd_pend  <= 1'b0;
      end else if (cmd.seek) begin
        scan_ptr <= CW'(rd_idx) + CW'(1);
        rd_pend  <= 1'b0;
      end else if (cmd.scan) begin
        if (scan_ptr < fill) begin
          scan_ptr <= scan_ptr + CW'(1);
          rd_pend  <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
      end
      if (cmd.add) begin
        fill <= fill + CW'(1);
      end else if (cmd.dec) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= s_tuser;
      item <= entry_t'(s_tdata);
    end
    if (cmd.scan && !cmd.seek && scan_ptr < fill) begin
      rd_idx <= scan_ptr[AW-1:0];
    end
    if (cmd.add) begin
      sel <= item;
    end else if (cmd.seek) begin
      sel <= cmd.upd ? rdata_upd : rdata;
    end else if (cmd.minsel && rd_pend && better) begin
      sel <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= cmd.res_code;
      out_entry  <= cmd.res_have ? sel : entry_t'('0);
      out_count  <= 5'(fill);
    end
  end

  always_comb begin
    sts.action   = act;
    sts.full     = fill == CW'(DEPTH);
    sts.empty    = fill == '0;
    sts.hit      = key_hit;
    sts.scan_end = !rd_pend && (scan_ptr >= fill);
    sts.out_busy = out_valid && !m_tready;
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {3'b000, out_count, out_entry};

endmodule

`default_nettype wire

FILE: rtl/core/okt_ctrl.sv
// ----------------------------------------------------------------------------
// okt_ctrl
// Controller: dispatches each action, runs the scan and the shift after a
// remove, and hands the result to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module okt_ctrl import okt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire okt_sts_t sts,
  output okt_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] res_code;
  logic [1:0] res_code_next;
  logic       res_have;
  logic       res_have_next;
  logic       is_min;
  logic       is_key;

  assign is_min = (sts.action == ACT_MINVAL) || (sts.action == ACT_MINWGT);
  assign is_key = (sts.action == ACT_LOOKUP) || (sts.action == ACT_UPDATE) ||
                  (sts.action == ACT_REMOVE);

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    res_have_next = res_have;
    cmd           = '0;
    cmd.res_code  = res_code;
    cmd.res_have  = res_have;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.action == ACT_ADD) begin
          if (sts.full) begin
            res_code_next = ST_FULL;
            res_have_next = 1'b0;
          end else begin
            cmd.add       = 1'b1;
            res_code_next = ST_OK;
            res_have_next = 1'b1;
          end
          state_next = S_FINISH;
        end else if (is_key || is_min) begin
          state_next = S_SCAN;
        end else begin
          res_code_next = ST_MISS;
          res_have_next = 1'b0;
          state_next    = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.minsel = is_min;
        if (is_key && sts.hit) begin
          cmd.seek      = 1'b1;
          cmd.upd       = sts.action == ACT_UPDATE;
          res_code_next = ST_OK;
          res_have_next = 1'b1;
          state_next    = (sts.action == ACT_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (sts.scan_end) begin
          if (is_min && !sts.empty) begin
            res_code_next = ST_OK;
            res_have_next = 1'b1;
          end else begin
            res_code_next = ST_MISS;
            res_have_next = 1'b0;
          end
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.scan  = 1'b1;
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          cmd.dec    = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= ST_OK;
      res_have <= 1'b0;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
      res_have <= res_have_next;
    end
  end

endmodule

`default_nettype wire
